FILE: rtl/clxm_pkg.sv
`default_nettype none
package clxm_pkg;

    localparam logic [63:0] LCG_MUL    = 64'd2862933555777941757;
    localparam logic [63:0] LCG_ADD    = 64'd7046029254386353087;
    localparam logic [31:0] MWC_MUL    = 32'd4294957665;
    localparam logic [63:0] SHIFT_INIT = 64'd4101842887655102017;

    typedef enum logic [2:0] {
        KIND_DRAW64 = 3'd0,
        KIND_DRAW32 = 3'd1,
        KIND_DRAW16 = 3'd2,
        KIND_DRAW8  = 3'd3,
        KIND_RANGE  = 3'd4,
        KIND_RESEED = 3'd5,
        KIND_RSVD6  = 3'd6,
        KIND_RSVD7  = 3'd7
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_MUL_D,
        ST_FINISH,
        ST_DIV,
        ST_RESULT,
        ST_OUT
    } state_t;

    // command from the controller to the datapath
    typedef struct packed {
        logic  load;        // capture the incoming word
        logic  reseed_init; // reset words, lcg from seed
        logic  mul_a;       // partial products, step a
        logic  mul_b;
        logic  mul_c;
        logic  mul_d;
        logic  finish;      // commit state update and mix
        logic  div_start;
        logic  div_step;
        logic  result;      // form the output word
    } cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       need_draw;
        logic       div_done;
        logic       zero_span;
        logic [1:0] warm_left;
    } status_t;

endpackage
`default_nettype wire

FILE: rtl/clxm_if.sv
`default_nettype none
interface clxm_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [63:0] range_min;
    logic [63:0] range_max;
    modport source (output valid, kind, range_min, range_max, input ready);
    modport sink   (input valid, kind, range_min, range_max, output ready);
endinterface

interface clxm_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic        span_error;
    modport source (output valid, value, span_error, input ready);
    modport sink   (input valid, value, span_error, output ready);
endinterface

interface clxm_cfg_if;
    logic        valid;
    logic        ready;
    logic [63:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/clxm_dpath.sv
`default_nettype none
module clxm_dpath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire clxm_pkg::cmd_t    cmd,
    output clxm_pkg::status_t      status,
    input  wire logic [2:0]        in_kind,
    input  wire logic [63:0]       in_min,
    input  wire logic [63:0]       in_max,
    input  wire logic              cfg_we,
    input  wire logic [63:0]       cfg_data,
    output logic [63:0]            value,
    output logic                   span_error
);
    import clxm_pkg::*;

    logic [63:0] seed_reg;
    logic [63:0] lcg_reg, shift_reg, carry_reg;
    logic [63:0] half_reg, byte_reg;
    logic [1:0]  halves_reg;
    logic [2:0]  bytes_reg;
    logic [2:0]  kind_reg;
    logic [63:0] min_reg, span_reg;
    logic [63:0] prod_reg;
    logic [63:0] mwc_reg;
    logic [63:0] draw_reg;
    logic [1:0]  warm_reg;
    logic [63:0] rem_reg, quo_reg;
    logic [6:0]  div_cnt_reg;
    logic [63:0] value_reg;
    logic        err_reg;

    logic [63:0] lcg_new, sh1, sh2, sh3, x1, x2, x3, mix;
    logic [64:0] rem_shift;
    logic [63:0] pp;

    // 64x64 low lcg product split into 32x32 partial products; otherwise the 32x32 mwc product
    always_comb
    begin
        pp = '0;
        priority if (cmd.mul_a)
            pp = lcg_reg[31:0] * LCG_MUL[31:0];
        else if (cmd.mul_b)
            pp = {lcg_reg[31:0] * LCG_MUL[63:32], 32'd0};
        else if (cmd.mul_c)
            pp = {lcg_reg[63:32] * LCG_MUL[31:0], 32'd0};
        else
            pp = {32'd0, carry_reg[31:0]} * {32'd0, MWC_MUL};
    end

    always_comb
    begin
        lcg_new = prod_reg + LCG_ADD;
        sh1 = shift_reg ^ (shift_reg >> 17);
        sh2 = sh1 ^ (sh1 << 31);
        sh3 = sh2 ^ (sh2 >> 8);
        x1 = lcg_new ^ (lcg_new << 21);
        x2 = x1 ^ (x1 >> 35);
        x3 = x2 ^ (x2 << 4);
        mix = (x3 + sh3) ^ mwc_reg;
        rem_shift = {rem_reg, quo_reg[63]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg   <= '0;
            lcg_reg    <= '0;
            shift_reg  <= SHIFT_INIT;
            carry_reg  <= 64'd1;
            half_reg   <= '0;
            byte_reg   <= '0;
            halves_reg <= '0;
            bytes_reg  <= '0;
            warm_reg   <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                seed_reg <= cfg_data;
            if (cmd.reseed_init)
            begin
                shift_reg <= SHIFT_INIT;
                carry_reg <= 64'd1;
                lcg_reg   <= seed_reg ^ SHIFT_INIT;
                warm_reg  <= 2'd3;
                half_reg  <= '0;
                byte_reg  <= '0;
                halves_reg <= '0;
                bytes_reg <= '0;
            end
            if (cmd.finish)
            begin
                lcg_reg <= lcg_new;
                // warm-up chaining: after first draw shift takes lcg, after second carry takes shift
                if (warm_reg == 2'd3)
                    shift_reg <= lcg_new;
                else
                    shift_reg <= sh3;
                if (warm_reg == 2'd2)
                    carry_reg <= sh3;
                else
                    carry_reg <= mwc_reg;
                if (warm_reg != 2'd0)
                    warm_reg <= warm_reg - 2'd1;
            end
            if (cmd.result)
            begin
                unique case (kind_t'(kind_reg))
                    KIND_DRAW16:
                        if (halves_reg != 2'd0)
                        begin
                            halves_reg <= halves_reg - 2'd1;
                            half_reg   <= half_reg >> 16;
                        end
                        else
                        begin
                            half_reg   <= draw_reg;
                            halves_reg <= 2'd3;
                        end
                    KIND_DRAW8:
                        if (bytes_reg != 3'd0)
                        begin
                            bytes_reg <= bytes_reg - 3'd1;
                            byte_reg  <= byte_reg >> 8;
                        end
                        else
                        begin
                            byte_reg  <= draw_reg;
                            bytes_reg <= 3'd7;
                        end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.div_start)
                div_cnt_reg <= 7'd64;
            else if (cmd.div_step)
                div_cnt_reg <= div_cnt_reg - 7'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= in_kind;
            min_reg  <= in_min;
            span_reg <= in_max - in_min;
        end
        if (cmd.mul_a)
            prod_reg <= pp;
        else if (cmd.mul_b || cmd.mul_c)
            prod_reg <= prod_reg + pp;
        if (cmd.mul_d)
            mwc_reg <= pp + {32'd0, carry_reg[63:32]};
        if (cmd.finish)
            draw_reg <= mix;
        // division starts on the commit cycle, so the dividend is the fresh mix
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= mix;
        end
        else if (cmd.div_step)
        begin
            // restoring division, one quotient bit a cycle
            if (rem_shift >= {1'b0, span_reg})
                rem_reg <= 64'(rem_shift - {1'b0, span_reg});
            else
                rem_reg <= rem_shift[63:0];
            quo_reg <= quo_reg << 1;
        end
        if (cmd.result)
        begin
            err_reg <= (kind_t'(kind_reg) == KIND_RANGE) && (span_reg == 64'd0);
            unique case (kind_t'(kind_reg))
                KIND_DRAW32:
                    value_reg <= {32'd0, draw_reg[31:0]};
                KIND_DRAW16:
                    value_reg <= (halves_reg != 2'd0) ?
                                 {48'd0, half_reg[31:16]} : {48'd0, draw_reg[15:0]};
                KIND_DRAW8:
                    value_reg <= (bytes_reg != 3'd0) ?
                                 {56'd0, byte_reg[15:8]} : {56'd0, draw_reg[7:0]};
                KIND_RANGE:
                    if (span_reg == 64'd0)
                        value_reg <= min_reg;
                    else
                        value_reg <= min_reg + rem_reg;
                default:
                    value_reg <= draw_reg;
            endcase
        end
    end

    always_comb
    begin
        status.kind      = kind_reg;
        status.need_draw = 1'b1;
        if (kind_t'(kind_reg) == KIND_DRAW16)
            status.need_draw = (halves_reg == 2'd0);
        else if (kind_t'(kind_reg) == KIND_DRAW8)
            status.need_draw = (bytes_reg == 3'd0);
        status.div_done  = (div_cnt_reg == 7'd0);
        status.zero_span = (span_reg == 64'd0);
        status.warm_left = warm_reg;
    end

    assign value      = value_reg;
    assign span_error = err_reg;

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> div_cnt_reg != 7'd0)
        else $error("division stepped past its end");
    a_halves: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.reseed_init |=> halves_reg == 2'd0 && bytes_reg == 3'd0)
        else $error("reserve counts not cleared by reseed");
    a_warm: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish && warm_reg != 2'd0 |=> warm_reg == $past(warm_reg) - 2'd1)
        else $error("warm-up count did not step");

endmodule
`default_nettype wire

FILE: rtl/clxm_ctrl.sv
`default_nettype none
module clxm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [2:0]        in_kind,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire clxm_pkg::status_t status,
    output clxm_pkg::cmd_t         cmd
);
    import clxm_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   take;

    assign take = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (take)
                begin
                    if (kind_t'(in_kind) == KIND_RESEED)
                        state_next = ST_MUL_A;
                    else if (kind_t'(in_kind) == KIND_RSVD6 || kind_t'(in_kind) == KIND_RSVD7)
                        state_next = ST_IDLE;
                    else
                        state_next = ST_OUT;
                end
            // decide whether a draw is needed
            ST_OUT:
                state_next = status.need_draw ? ST_MUL_A : ST_RESULT;
            ST_MUL_A:  state_next = ST_MUL_B;
            ST_MUL_B:  state_next = ST_MUL_C;
            ST_MUL_C:  state_next = ST_MUL_D;
            ST_MUL_D:  state_next = ST_FINISH;
            ST_FINISH:
                priority if (status.warm_left > 2'd1)
                    state_next = ST_MUL_A;
                else if (status.warm_left == 2'd1)
                    state_next = ST_IDLE;
                else if (kind_t'(status.kind) == KIND_RANGE && !status.zero_span)
                    state_next = ST_DIV;
                else
                    state_next = ST_RESULT;
            ST_DIV:
                state_next = status.div_done ? ST_RESULT : ST_DIV;
            // result holds here until the output register is free
            ST_RESULT:
                state_next = cmd.result ? ST_IDLE : ST_RESULT;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = !out_valid_reg || out_ready;
                cmd.load = take;
                cmd.reseed_init = take && kind_t'(in_kind) == KIND_RESEED;
            end
            ST_MUL_A:  cmd.mul_a = 1'b1;
            ST_MUL_B:  cmd.mul_b = 1'b1;
            ST_MUL_C:  cmd.mul_c = 1'b1;
            ST_MUL_D:  cmd.mul_d = 1'b1;
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                cmd.div_start = 1'b1;
            end
            ST_DIV:    cmd.div_step = !status.div_done;
            ST_RESULT: cmd.result = !out_valid_reg || out_ready;
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (cmd.result)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == ST_IDLE)
        else $error("ready outside idle");
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result |=> out_valid_reg)
        else $error("result not presented");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg)
        else $error("result dropped while stalled");

endmodule
`default_nettype wire

FILE: rtl/combined_lcg_xorshift_mwc_prng.sv
`default_nettype none
// combined lcg / xorshift / multiply-with-carry generator
// channels: req (kind, range_min, range_max), rsp (value, span_error),
// cfg (seed write, always ready; write it only while no item is in flight)
// kinds: draw64, draw32, draw16, draw8, range draw, reseed; kinds 6, 7 dropped
// a draw gives its word after decode, three lcg partial products, the mwc
// product, commit, then the output load; the next item is taken only once
// the controller is back in idle, so drawing items do not overlap
// narrow draws served from the reserve buffers skip the draw and go from
// decode straight to the output load
// a range draw with a nonzero span runs the bit-serial remainder between commit and the output load
// reseed runs three warm-up draws and gives no word
// one item is in flight at a time; req ready is high only when idle and the
// output register can take a word
// a stalled receiver holds the word in the output register; no new item is
// accepted until that word is taken
// reset: lcg word 0, xorshift word at its fixed start, mwc word 1, seed 0,
// reserves empty; draws before a reseed run from that state
module combined_lcg_xorshift_mwc_prng (
    input  wire logic  clk,
    input  wire logic  rst_n,
    clxm_in_if.sink    req,
    clxm_out_if.source rsp,
    clxm_cfg_if.sink   cfg
);
    import clxm_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg.ready = 1'b1;

    clxm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_kind   (req.kind),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    clxm_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_kind    (req.kind),
        .in_min     (req.range_min),
        .in_max     (req.range_max),
        .cfg_we     (cfg.valid),
        .cfg_data   (cfg.data),
        .value      (rsp.value),
        .span_error (rsp.span_error)
    );

endmodule
`default_nettype wire

FILE: dv/tb_combined_lcg_xorshift_mwc_prng.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_combined_lcg_xorshift_mwc_prng;
    import clxm_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 120;

    typedef struct packed {
        logic [63:0] value;
        logic        span_error;
    } draw_word_t;

    logic clk;
    logic rst_n;

    clxm_in_if  req ();
    clxm_out_if rsp ();
    clxm_cfg_if cfg ();

    combined_lcg_xorshift_mwc_prng dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // predictor state
    logic [63:0] seed_reg;
    logic [63:0] lcg_w;
    logic [63:0] xs_w;
    logic [63:0] mwc_w;
    logic [63:0] half_buf;
    logic [1:0]  half_cnt;
    logic [63:0] byte_buf;
    logic [2:0]  byte_cnt;

    draw_word_t expected_words[$];
    int         error_count;
    int         idle_count = 0;
    bit         quiet;

    function automatic logic [63:0] next_draw();
        logic [63:0] x;
        lcg_w = lcg_w * LCG_MUL + LCG_ADD;
        xs_w  = xs_w ^ (xs_w >> 17);
        xs_w  = xs_w ^ (xs_w << 31);
        xs_w  = xs_w ^ (xs_w >> 8);
        mwc_w = {32'd0, MWC_MUL} * {32'd0, mwc_w[31:0]} + {32'd0, mwc_w[63:32]};
        x = lcg_w ^ (lcg_w << 21);
        x = x ^ (x >> 35);
        x = x ^ (x << 4);
        return (x + xs_w) ^ mwc_w;
    endfunction

    task automatic predict_word(input kind_t k, input logic [63:0] lo,
                                input logic [63:0] hi);
        draw_word_t w;
        logic [63:0] span;
        logic [63:0] r;
        w = '0;
        case (k)
            KIND_DRAW64: w.value = next_draw();
            KIND_DRAW32:
            begin
                r = next_draw();
                w.value = {32'd0, r[31:0]};
            end
            KIND_DRAW16:
            begin
                if (half_cnt != 0)
                begin
                    half_cnt = half_cnt - 2'd1;
                    half_buf = half_buf >> 16;
                end
                else
                begin
                    half_buf = next_draw();
                    half_cnt = 2'd3;
                end
                w.value = {48'd0, half_buf[15:0]};
            end
            KIND_DRAW8:
            begin
                if (byte_cnt != 0)
                begin
                    byte_cnt = byte_cnt - 3'd1;
                    byte_buf = byte_buf >> 8;
                end
                else
                begin
                    byte_buf = next_draw();
                    byte_cnt = 3'd7;
                end
                w.value = {56'd0, byte_buf[7:0]};
            end
            KIND_RANGE:
            begin
                span = hi - lo;
                r = next_draw();
                if (span == 0)
                begin
                    w.value = lo;
                    w.span_error = 1'b1;
                end
                else
                    w.value = lo + r % span;
            end
            KIND_RESEED:
            begin
                xs_w  = SHIFT_INIT;
                mwc_w = 64'd1;
                lcg_w = seed_reg ^ xs_w;
                void'(next_draw());
                xs_w = lcg_w;
                void'(next_draw());
                mwc_w = xs_w;
                void'(next_draw());
                half_buf = '0;
                half_cnt = '0;
                byte_buf = '0;
                byte_cnt = '0;
                return;
            end
            default: return;
        endcase
        expected_words.push_back(w);
    endtask

    task automatic random_gap();
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    // valid stays high after acceptance until the next word, a random gap or a drain
    task automatic send_word(input kind_t k, input logic [63:0] lo,
                             input logic [63:0] hi);
        random_gap();
        req.valid     <= 1'b1;
        req.kind      <= k;
        req.range_min <= lo;
        req.range_max <= hi;
        do
            @(posedge clk);
        while (!req.ready);
        predict_word(k, lo, hi);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic wait_drained();
        req.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input logic [63:0] s);
        wait_drained();
        cfg.valid <= 1'b1;
        cfg.data  <= s;
        do
            @(posedge clk);
        while (!cfg.ready);
        seed_reg = s;
        cfg.valid <= 1'b0;
    endtask

    // receiver side: each taken word is checked here; ready is driven below with random stall bursts
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t unexpected word: expected none, actual %h %b",
                             $time, rsp.value, rsp.span_error);
                    error_count++;
                end
                else
                begin
                    draw_word_t e;
                    e = expected_words.pop_front();
                    if (rsp.value !== e.value)
                    begin
                        $display("%0t value mismatch: expected %h, actual %h",
                                 $time, e.value, rsp.value);
                        error_count++;
                    end
                    if (rsp.span_error !== e.span_error)
                    begin
                        $display("%0t span_error mismatch: expected %b, actual %b",
                                 $time, e.span_error, rsp.span_error);
                        error_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        int stall;
        stall = 0;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                stall--;
                rsp.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 16) - 1;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready)
            || (cfg.valid && cfg.ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count > STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic test_before_reseed();
        send_word(KIND_DRAW64, '0, '0);
        send_word(KIND_DRAW32, '0, '0);
        send_word(KIND_DRAW16, '0, '0);
        send_word(KIND_DRAW8, '0, '0);
    endtask

    task automatic test_directed();
        write_seed(64'd0);
        send_word(KIND_RESEED, '0, '0);
        send_word(KIND_RANGE, 64'd5, 64'd5);
        send_word(KIND_RANGE, '1, '1);
        send_word(KIND_RANGE, 64'd0, '1);
        send_word(KIND_RANGE, '1, 64'd0);
        send_word(KIND_RANGE, 64'd10, 64'd3);
        send_word(KIND_RANGE, 64'd7, 64'd8);
        send_word(KIND_RSVD6, '1, '1);
        send_word(KIND_RSVD7, '0, '0);
        repeat (5) send_word(KIND_DRAW16, '0, '0);
        repeat (9) send_word(KIND_DRAW8, '0, '0);
        write_seed('1);
        send_word(KIND_RESEED, '0, '0);
        send_word(KIND_DRAW16, '0, '0);
        send_word(KIND_DRAW64, '0, '0);
        send_word(KIND_DRAW8, '0, '0);
    endtask

    task automatic test_random(input int count);
        kind_t k;
        logic [63:0] lo;
        logic [63:0] hi;
        for (int i = 0; i < count; i++)
        begin
            k = kind_t'($urandom_range(0, 4));
            if ($urandom_range(0, 40) == 0)
                k = kind_t'($urandom_range(5, 7));
            lo = rand64();
            hi = rand64();
            case ($urandom_range(0, 5))
                0: hi = lo;
                1: hi = lo + $urandom_range(1, 100);
                2: lo = lo >> $urandom_range(0, 63);
                default: ;
            endcase
            send_word(k, lo, hi);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        quiet         = 1'b0;
        error_count   = 0;
        req.valid     = 1'b0;
        req.kind      = KIND_DRAW64;
        req.range_min = '0;
        req.range_max = '0;
        cfg.valid     = 1'b0;
        cfg.data      = '0;
        seed_reg = '0;
        lcg_w    = '0;
        xs_w     = SHIFT_INIT;
        mwc_w    = 64'd1;
        half_buf = '0;
        half_cnt = '0;
        byte_buf = '0;
        byte_cnt = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_before_reseed();
        test_directed();
        for (int p = 0; p < 5; p++)
        begin
            write_seed(rand64());
            send_word(KIND_RESEED, '0, '0);
            test_random(250);
        end
        quiet = 1'b1;
        test_random(250);
        wait_drained();

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire

FILE: sim.f
rtl/clxm_pkg.sv
rtl/clxm_if.sv
rtl/clxm_dpath.sv
rtl/clxm_ctrl.sv
rtl/combined_lcg_xorshift_mwc_prng.sv
dv/tb_combined_lcg_xorshift_mwc_prng.sv
